FILE: rtl/sqts_pkg.sv
package sqts_pkg;

    // default geometry
    localparam int NUM_QUEUES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    // request field widths fixed by the port list
    localparam int IDX_W = 3;
    localparam int VAL_W = 32;
    localparam int CNT_W = 32;

    // operation codes
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_SERVE   = 1'b1;

    // classified request handed from front to back
    typedef struct packed {
        logic             serve;
        logic             in_range;
        logic [IDX_W-1:0] qi;
        logic [VAL_W-1:0] value;
    } t_req;

    // front to back link
    typedef struct packed {
        logic valid;
        t_req req;
    } t_link;

endpackage

FILE: rtl/sqts_front.sv
module sqts_front #(
    parameter int NUM_QUEUES = sqts_pkg::NUM_QUEUES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_op,
    input  logic [sqts_pkg::IDX_W-1:0]   i_queue_index,
    input  logic [sqts_pkg::VAL_W-1:0]   i_value,
    input  logic                         i_pop,
    output logic                         o_busy,
    output sqts_pkg::t_link              o_link
);

    localparam int FD = 2;

    sqts_pkg::t_req r_fifo [FD];
    logic [0:0] r_rd_ptr, n_rd_ptr;
    logic [0:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_count, n_count;
    sqts_pkg::t_req w_req;
    logic w_push;
    logic w_pop;

    // classify the incoming request
    always_comb begin
        w_req.serve    = (i_op == sqts_pkg::OP_SERVE);
        w_req.in_range = (32'(i_queue_index) < NUM_QUEUES);
        w_req.qi       = i_queue_index;
        w_req.value    = i_value;
    end

    assign o_busy = (r_count == 2'(FD));
    assign w_push = i_start && !o_busy;
    assign w_pop  = i_pop && (r_count != 2'd0);

    // pointer and count update
    always_comb begin
        n_rd_ptr = w_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_count  = r_count + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    // request storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_req;
        end
    end

    assign o_link.valid = (r_count != 2'd0);
    assign o_link.req   = r_fifo[r_rd_ptr];

endmodule

FILE: rtl/sqts_back.sv
module sqts_back #(
    parameter int NUM_QUEUES  = sqts_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = sqts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sqts_pkg::t_link             i_link,
    output logic                        o_pop,
    output logic                        o_valid,
    output logic [sqts_pkg::IDX_W-1:0]  o_served_queue,
    output logic [sqts_pkg::VAL_W-1:0]  o_departed_value,
    output logic                        o_still_waiting,
    output logic                        o_idle,
    output logic                        o_dropped,
    output logic [sqts_pkg::CNT_W-1:0]  o_serve_total,
    output logic [sqts_pkg::CNT_W-1:0]  o_move_total,
    output logic [sqts_pkg::CNT_W-1:0]  o_served_wait
);

    localparam int QW = $clog2(NUM_QUEUES);
    localparam int DW = $clog2(QUEUE_DEPTH);
    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam int L  = QW;
    localparam int P  = 1 << L;
    localparam int CW = sqts_pkg::CNT_W;

    // queue memory
    logic [sqts_pkg::VAL_W-1:0] r_mem [NUM_QUEUES][QUEUE_DEPTH];
    logic [sqts_pkg::VAL_W-1:0] r_rd_data;

    // scheduler state
    logic [DW-1:0] r_head [NUM_QUEUES];
    logic [OW-1:0] r_occ  [NUM_QUEUES];
    logic [CW-1:0] r_wait [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] r_served, n_served;
    logic [QW-1:0] r_scan;
    logic [CW-1:0] r_serve_cnt;
    logic [CW-1:0] r_move_cnt;

    // result registers
    logic r_valid, r_pop_data, r_sw, r_idle, r_drop;
    logic [sqts_pkg::IDX_W-1:0] r_sq;
    logic [CW-1:0] r_swait;

    // min tree signals
    logic [OW-1:0] w_t_occ [L+1][P];
    logic [QW-1:0] w_t_idx [L+1][P];
    logic          w_t_ok  [L+1][P];
    logic [NUM_QUEUES-1:0] w_nonempty, w_elig, w_mask;
    logic          w_any;
    logic [QW-1:0] w_pick;

    sqts_pkg::t_req w_req;
    logic          w_enq, w_srv, w_full, w_do_enq, w_do_srv;
    logic [QW-1:0] w_eq;
    logic [DW:0]   w_tail_sum;
    logic [DW-1:0] w_tail;
    logic [DW-1:0] w_head_nx;
    logic [QW-1:0] w_dist;

    assign w_req = i_link.req;
    assign o_pop = i_link.valid;
    assign w_enq = i_link.valid && !w_req.serve;
    assign w_srv = i_link.valid && w_req.serve;
    assign w_eq  = QW'(w_req.qi);

    // eligibility masks for this tour
    always_comb begin
        for (int i = 0; i < NUM_QUEUES; i++) begin
            w_nonempty[i] = (r_occ[i] != '0);
        end
        w_elig = w_nonempty & ~r_served;
        w_mask = (w_elig != '0) ? w_elig : w_nonempty;
        w_any  = (w_nonempty != '0);
    end

    // shortest queue pick, lowest index on ties
    always_comb begin
        for (int lv = 0; lv <= L; lv++) begin
            for (int k = 0; k < P; k++) begin
                w_t_occ[lv][k] = '0;
                w_t_idx[lv][k] = '0;
                w_t_ok[lv][k]  = 1'b0;
            end
        end
        for (int k = 0; k < P; k++) begin
            if (k < NUM_QUEUES) begin
                w_t_occ[0][k] = r_occ[k];
                w_t_idx[0][k] = QW'(k);
                w_t_ok[0][k]  = w_mask[k];
            end
        end
        for (int lv = 0; lv < L; lv++) begin
            for (int k = 0; k < (P >> (lv + 1)); k++) begin
                if (w_t_ok[lv][2*k+1] && (!w_t_ok[lv][2*k] ||
                        w_t_occ[lv][2*k+1] < w_t_occ[lv][2*k])) begin
                    w_t_occ[lv+1][k] = w_t_occ[lv][2*k+1];
                    w_t_idx[lv+1][k] = w_t_idx[lv][2*k+1];
                end else begin
                    w_t_occ[lv+1][k] = w_t_occ[lv][2*k];
                    w_t_idx[lv+1][k] = w_t_idx[lv][2*k];
                end
                w_t_ok[lv+1][k] = w_t_ok[lv][2*k] || w_t_ok[lv][2*k+1];
            end
        end
        w_pick = w_t_idx[L][0];
    end

    // enqueue address and serve bookkeeping
    always_comb begin
        w_full     = !w_req.in_range || (r_occ[w_eq] >= OW'(QUEUE_DEPTH));
        w_do_enq   = w_enq && !w_full;
        w_do_srv   = w_srv && w_any;
        w_tail_sum = {1'b0, r_head[w_eq]} + (DW+1)'(r_occ[w_eq]);
        w_tail     = (w_tail_sum >= (DW+1)'(QUEUE_DEPTH)) ?
                     DW'(w_tail_sum - (DW+1)'(QUEUE_DEPTH)) : DW'(w_tail_sum);
        w_head_nx  = (32'(r_head[w_pick]) == QUEUE_DEPTH - 1) ?
                     '0 : r_head[w_pick] + 1'b1;
        w_dist     = (r_scan > w_pick) ? r_scan - w_pick : w_pick - r_scan;
        n_served   = (w_elig != '0) ? r_served : '0;
        if (w_do_srv) begin
            n_served[w_pick] = 1'b1;
        end
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (w_do_enq) begin
            r_mem[w_eq][w_tail] <= w_req.value;
        end
        r_rd_data <= r_mem[w_pick][r_head[w_pick]];
    end

    // scheduler state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= '0;
                r_occ[i]  <= '0;
                r_wait[i] <= '0;
            end
            r_served    <= '0;
            r_scan      <= '0;
            r_serve_cnt <= '0;
            r_move_cnt  <= '0;
        end else begin
            if (w_do_enq) begin
                r_occ[w_eq] <= r_occ[w_eq] + 1'b1;
            end
            if (w_srv) begin
                r_served <= n_served;
            end
            if (w_do_srv) begin
                r_head[w_pick] <= w_head_nx;
                r_occ[w_pick]  <= r_occ[w_pick] - 1'b1;
                r_scan         <= w_pick;
                r_serve_cnt    <= r_serve_cnt + 1'b1;
                r_move_cnt     <= r_move_cnt + CW'(w_dist);
                for (int i = 0; i < NUM_QUEUES; i++) begin
                    if (w_nonempty[i] && (QW'(i) != w_pick)) begin
                        r_wait[i] <= r_wait[i] + 1'b1;
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_link.valid;
        end
        r_pop_data <= w_do_srv;
        r_sq       <= w_do_srv ? sqts_pkg::IDX_W'(w_pick) : '0;
        r_sw       <= w_do_srv && (r_occ[w_pick] > OW'(1));
        r_idle     <= w_srv && !w_any;
        r_drop     <= w_enq && w_full;
        r_swait    <= w_do_srv ? r_wait[w_pick] : '0;
    end

    assign o_valid          = r_valid;
    assign o_served_queue   = r_sq;
    assign o_departed_value = r_pop_data ? r_rd_data : '0;
    assign o_still_waiting  = r_sw;
    assign o_idle           = r_idle;
    assign o_dropped        = r_drop;
    assign o_serve_total    = r_serve_cnt;
    assign o_move_total     = r_move_cnt;
    assign o_served_wait    = r_swait;

endmodule

FILE: rtl/shortest_queue_tour_scheduler_unit.sv
// shortest queue tour scheduler
// requests: start with i_op, i_queue_index, i_value; taken at an edge where
//   start is high and busy is low. op 0 appends i_value to queue
//   i_queue_index (o_dropped when full or out of range), op 1 serves the shortest
//   non-empty queue not yet served in this tour, lowest index on ties.
// results: one per request, shown for exactly one cycle with o_valid high,
//   in request order; the receiver cannot stall, so none is ever held back.
// order: an accepted request is written into the front queue, and the back
//   registers its result. throughput: one request per cycle; the front queue pops
//   every cycle it holds a request and the back does the pick, memory access
//   and counter update as it pops the request, with the queue memory read registered.
// busy is high only while the two-entry request queue is full; since the back
//   drains one entry every cycle the queue never fills and busy stays low.
// reset (synchronous, active low) empties all queues, clears tour marks,
//   scanner, serve, move and wait counters; queue memory holds no reset value
//   and its contents reach o_departed_value only after they are written.
module shortest_queue_tour_scheduler_unit #(
    parameter int NUM_QUEUES  = sqts_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = sqts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_op,
    input  logic [sqts_pkg::IDX_W-1:0]  i_queue_index,
    input  logic [sqts_pkg::VAL_W-1:0]  i_value,
    output logic                        o_valid,
    output logic [sqts_pkg::IDX_W-1:0]  o_served_queue,
    output logic [sqts_pkg::VAL_W-1:0]  o_departed_value,
    output logic                        o_still_waiting,
    output logic                        o_idle,
    output logic                        o_dropped,
    output logic [sqts_pkg::CNT_W-1:0]  o_serve_total,
    output logic [sqts_pkg::CNT_W-1:0]  o_move_total,
    output logic [sqts_pkg::CNT_W-1:0]  o_served_wait
);

    sqts_pkg::t_link w_link;
    logic            w_pop;

    // request intake and classification
    sqts_front #(
        .NUM_QUEUES (NUM_QUEUES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_op          (i_op),
        .i_queue_index (i_queue_index),
        .i_value       (i_value),
        .i_pop         (w_pop),
        .o_busy        (busy),
        .o_link        (w_link)
    );

    // queue store and scheduling
    sqts_back #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_link           (w_link),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .o_served_queue   (o_served_queue),
        .o_departed_value (o_departed_value),
        .o_still_waiting  (o_still_waiting),
        .o_idle           (o_idle),
        .o_dropped        (o_dropped),
        .o_serve_total    (o_serve_total),
        .o_move_total     (o_move_total),
        .o_served_wait    (o_served_wait)
    );

endmodule

FILE: rtl/sqts_checker.sv
module sqts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        o_idle,
    input logic        o_dropped,
    input logic        o_still_waiting,
    input logic [31:0] o_departed_value
);

    // each accepted request gives a result, through the front queue and the result register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("result missing after request");

    // no result without a request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result without request");

    // idle serve pops nothing
    a_idle_empty: assert property (@(posedge i_clk)
        (o_valid && o_idle) |-> (o_departed_value == '0 && !o_still_waiting))
        else $error("idle result carries data");

    // drop and idle are exclusive
    a_flags: assert property (@(posedge i_clk)
        o_valid |-> !(o_idle && o_dropped))
        else $error("idle and drop together");

endmodule

bind shortest_queue_tour_scheduler_unit sqts_checker u_sqts_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_idle           (o_idle),
    .o_dropped        (o_dropped),
    .o_still_waiting  (o_still_waiting),
    .o_departed_value (o_departed_value)
);
